### rtl/si_pkg.sv
// shared types and constants for the segment intersection unit
// depends on nothing; used by si_muldiv, segment_intersection_unit and the testbench
`timescale 1ns / 1ps

package si_pkg;

    // width of the fixed point crossing point on the result ports
    localparam int OUT_BITS = 24;

    // sideband that travels with each word through the divider pipeline
    typedef struct packed {
        logic vld;
        logic hit;
        logic par;
        logic neg;
    } t_tag;

endpackage

### rtl/si_muldiv.sv
// pipelined scaled divider: floor(s * n / d) for n <= d, one scale bit per stage
// depends on si_pkg (t_tag)
`timescale 1ns / 1ps

module si_muldiv #(
    parameter int SW = 24,
    parameter int MW = 33,
    parameter int CW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  si_pkg::t_tag          i_tag,
    input  logic [SW-1:0]         i_s,
    input  logic [MW-1:0]         i_n,
    input  logic [MW-1:0]         i_d,
    input  logic signed [CW-1:0]  i_start,
    output si_pkg::t_tag          o_tag,
    output logic [SW-1:0]         o_quo,
    output logic signed [CW-1:0]  o_start
);

    localparam int RW = MW + 2;

    // per stage registers
    si_pkg::t_tag        r_tag   [SW];
    logic [MW-1:0]       r_rem   [SW];
    logic [SW-1:0]       r_quo   [SW];
    logic [SW-1:0]       r_s     [SW];
    logic [MW-1:0]       r_n     [SW];
    logic [MW-1:0]       r_d     [SW];
    logic signed [CW-1:0] r_start [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        si_pkg::t_tag        p_tag;
        logic [MW-1:0]       p_rem;
        logic [SW-1:0]       p_quo;
        logic [SW-1:0]       p_s;
        logic [MW-1:0]       p_n;
        logic [MW-1:0]       p_d;
        logic signed [CW-1:0] p_start;
        logic [RW-1:0]       w_sum;
        logic [RW-1:0]       w_sub1;
        logic [RW-1:0]       w_sub2;
        logic                w_ge1;
        logic                w_ge2;
        logic [1:0]          w_k;
        logic [MW-1:0]       n_rem;
        logic [SW-1:0]       n_quo;

        // previous stage, or the fresh word at the head
        if (k == 0) begin : g_head
            assign p_tag   = i_tag;
            assign p_rem   = '0;
            assign p_quo   = '0;
            assign p_s     = i_s;
            assign p_n     = i_n;
            assign p_d     = i_d;
            assign p_start = i_start;
        end else begin : g_body
            assign p_tag   = r_tag[k-1];
            assign p_rem   = r_rem[k-1];
            assign p_quo   = r_quo[k-1];
            assign p_s     = r_s[k-1];
            assign p_n     = r_n[k-1];
            assign p_d     = r_d[k-1];
            assign p_start = r_start[k-1];
        end

        // shift in one scale bit, then take out zero, one or two divisors
        always_comb begin
            w_sum  = {1'b0, p_rem, 1'b0} + (p_s[SW-1] ? RW'(p_n) : RW'(0));
            w_sub1 = w_sum - RW'(p_d);
            w_sub2 = w_sum - RW'({p_d, 1'b0});
            w_ge2  = (w_sum >= RW'({p_d, 1'b0}));
            w_ge1  = (w_sum >= RW'(p_d));
            w_k    = {w_ge2, w_ge1 & ~w_ge2};
            if (w_ge2) begin
                n_rem = w_sub2[MW-1:0];
            end else if (w_ge1) begin
                n_rem = w_sub1[MW-1:0];
            end else begin
                n_rem = w_sum[MW-1:0];
            end
            n_quo = (p_quo << 1) + SW'(w_k);
        end

        // control bits of the stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else begin
                r_tag[k] <= p_tag;
            end
        end

        // data of the stage
        always_ff @(posedge i_clk) begin
            r_rem[k]   <= n_rem;
            r_quo[k]   <= n_quo;
            r_s[k]     <= p_s << 1;
            r_n[k]     <= p_n;
            r_d[k]     <= p_d;
            r_start[k] <= p_start;
        end
    end

    assign o_tag   = r_tag[SW-1];
    assign o_quo   = r_quo[SW-1];
    assign o_start = r_start[SW-1];

endmodule

### rtl/segment_intersection_unit.sv
// top level of the 2d segment intersection unit
// depends on si_pkg and si_muldiv
`timescale 1ns / 1ps

// one word accepted every cycle; busy never rises
// a result passes six front stages (input, differences, products, numerators, sign folding
// and range tests), one divider stage per quotient bit and one output stage; the result
// strobe cannot be held off
// synchronous active low reset clears all valid bits; the pipeline is empty after reset
module segment_intersection_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_BITS-1:0]        i_a_start_x,
    input  logic signed [COORD_BITS-1:0]        i_a_start_y,
    input  logic signed [COORD_BITS-1:0]        i_a_end_x,
    input  logic signed [COORD_BITS-1:0]        i_a_end_y,
    input  logic signed [COORD_BITS-1:0]        i_b_start_x,
    input  logic signed [COORD_BITS-1:0]        i_b_start_y,
    input  logic signed [COORD_BITS-1:0]        i_b_end_x,
    input  logic signed [COORD_BITS-1:0]        i_b_end_y,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic                                o_parallel,
    output logic signed [si_pkg::OUT_BITS-1:0]  o_point_x,
    output logic signed [si_pkg::OUT_BITS-1:0]  o_point_y
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;          // coordinate differences
    localparam int PW = 2 * C + 2;      // products and numerators
    localparam int MW = 2 * C + 1;      // numerator magnitudes
    localparam int SW = C + FRAC_BITS;  // scaled direction and quotient
    localparam int W  = SW + 2;         // final point before trimming
    localparam int OW = si_pkg::OUT_BITS;

    logic w_accept;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    // stage 1: input register
    logic                 r1_vld;
    logic signed [C-1:0]  r1_ax0, r1_ay0, r1_ax1, r1_ay1;
    logic signed [C-1:0]  r1_bx0, r1_by0, r1_bx1, r1_by1;

    // stage 2: differences
    logic                 r2_vld;
    logic signed [DW-1:0] r2_dax, r2_day, r2_dbx, r2_dby, r2_ox, r2_oy;
    logic signed [C-1:0]  r2_ax0, r2_ay0;

    // stage 3: products
    logic                 r3_vld;
    logic signed [PW-1:0] r3_m0, r3_m1, r3_m2, r3_m3, r3_m4, r3_m5;
    logic signed [DW-1:0] r3_dax, r3_day;
    logic signed [C-1:0]  r3_ax0, r3_ay0;

    // stage 4: denominator and numerators
    logic                 r4_vld;
    logic signed [PW-1:0] r4_den, r4_sn, r4_tn;
    logic signed [DW-1:0] r4_dax, r4_day;
    logic signed [C-1:0]  r4_ax0, r4_ay0;

    // stage 5: sign normalized values
    logic                 r5_vld;
    logic                 r5_par;
    logic [MW-1:0]        r5_dp;
    logic signed [PW-1:0] r5_sp, r5_tp;
    logic [MW-1:0]        r5_nmag;
    logic [C-1:0]         r5_sx, r5_sy;
    logic                 r5_negx, r5_negy;
    logic signed [C-1:0]  r5_ax0, r5_ay0;

    // stage 6: range tests, divider operands
    si_pkg::t_tag         r6_tagx, r6_tagy;
    logic [SW-1:0]        r6_sx, r6_sy;
    logic [MW-1:0]        r6_n, r6_d;
    logic signed [C-1:0]  r6_ax0, r6_ay0;

    // combinational helpers
    logic                 w_den_neg;
    logic signed [PW-1:0] w_dp, w_tmag;
    logic signed [DW-1:0] w_dxmag, w_dymag;
    logic                 w_hit;

    always_comb begin
        w_den_neg = r4_den[PW-1];
        w_dp      = w_den_neg ? -r4_den : r4_den;
        w_tmag    = r4_tn[PW-1] ? -r4_tn : r4_tn;
        w_dxmag   = r4_dax[DW-1] ? -r4_dax : r4_dax;
        w_dymag   = r4_day[DW-1] ? -r4_day : r4_day;
        w_hit     = r5_par |
                    (~r5_sp[PW-1] && (r5_sp[MW-1:0] <= r5_dp) &&
                     ~r5_tp[PW-1] && (r5_tp[MW-1:0] <= r5_dp));
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_tagx <= '0;
            r6_tagy <= '0;
        end else begin
            r1_vld <= w_accept;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_tagx <= '{vld: r5_vld, hit: w_hit, par: r5_par, neg: r5_negx};
            r6_tagy <= '{vld: r5_vld, hit: w_hit, par: r5_par, neg: r5_negy};
        end
    end

    // data of the front stages
    always_ff @(posedge i_clk) begin
        // capture the word
        r1_ax0 <= i_a_start_x;
        r1_ay0 <= i_a_start_y;
        r1_ax1 <= i_a_end_x;
        r1_ay1 <= i_a_end_y;
        r1_bx0 <= i_b_start_x;
        r1_by0 <= i_b_start_y;
        r1_bx1 <= i_b_end_x;
        r1_by1 <= i_b_end_y;

        // directions and start offset
        r2_dax <= DW'(r1_ax1) - DW'(r1_ax0);
        r2_day <= DW'(r1_ay1) - DW'(r1_ay0);
        r2_dbx <= DW'(r1_bx1) - DW'(r1_bx0);
        r2_dby <= DW'(r1_by1) - DW'(r1_by0);
        r2_ox  <= DW'(r1_ax0) - DW'(r1_bx0);
        r2_oy  <= DW'(r1_ay0) - DW'(r1_by0);
        r2_ax0 <= r1_ax0;
        r2_ay0 <= r1_ay0;

        // cross product terms
        r3_m0  <= r2_dax * r2_dby;
        r3_m1  <= r2_dbx * r2_day;
        r3_m2  <= r2_dax * r2_oy;
        r3_m3  <= r2_day * r2_ox;
        r3_m4  <= r2_dbx * r2_oy;
        r3_m5  <= r2_dby * r2_ox;
        r3_dax <= r2_dax;
        r3_day <= r2_day;
        r3_ax0 <= r2_ax0;
        r3_ay0 <= r2_ay0;

        // denominator and numerators
        r4_den <= r3_m0 - r3_m1;
        r4_sn  <= r3_m2 - r3_m3;
        r4_tn  <= r3_m4 - r3_m5;
        r4_dax <= r3_dax;
        r4_day <= r3_day;
        r4_ax0 <= r3_ax0;
        r4_ay0 <= r3_ay0;

        // fold the denominator sign into the numerators
        r5_par  <= (r4_den == '0);
        r5_dp   <= w_dp[MW-1:0];
        r5_sp   <= w_den_neg ? -r4_sn : r4_sn;
        r5_tp   <= w_den_neg ? -r4_tn : r4_tn;
        r5_nmag <= w_tmag[MW-1:0];
        r5_sx   <= w_dxmag[C-1:0];
        r5_sy   <= w_dymag[C-1:0];
        r5_negx <= r4_dax[DW-1] ^ r4_tn[PW-1] ^ w_den_neg;
        r5_negy <= r4_day[DW-1] ^ r4_tn[PW-1] ^ w_den_neg;
        r5_ax0  <= r4_ax0;
        r5_ay0  <= r4_ay0;

        // divider operands; parallel and miss give a zero offset
        r6_sx  <= SW'(r5_sx) << FRAC_BITS;
        r6_sy  <= SW'(r5_sy) << FRAC_BITS;
        r6_n   <= (w_hit && !r5_par) ? r5_nmag : MW'(0);
        r6_d   <= r5_par ? MW'(1) : r5_dp;
        r6_ax0 <= r5_ax0;
        r6_ay0 <= r5_ay0;
    end

    // one divider lane per axis
    si_pkg::t_tag         w_tagx, w_tagy;
    logic [SW-1:0]        w_qx, w_qy;
    logic signed [C-1:0]  w_stx, w_sty;

    si_muldiv #(
        .SW (SW),
        .MW (MW),
        .CW (C)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r6_tagx),
        .i_s     (r6_sx),
        .i_n     (r6_n),
        .i_d     (r6_d),
        .i_start (r6_ax0),
        .o_tag   (w_tagx),
        .o_quo   (w_qx),
        .o_start (w_stx)
    );

    si_muldiv #(
        .SW (SW),
        .MW (MW),
        .CW (C)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r6_tagy),
        .i_s     (r6_sy),
        .i_n     (r6_n),
        .i_d     (r6_d),
        .i_start (r6_ay0),
        .o_tag   (w_tagy),
        .o_quo   (w_qy),
        .o_start (w_sty)
    );

    // apply sign and add the scaled start
    logic signed [W-1:0] w_offx, w_offy, w_px, w_py;

    always_comb begin
        w_offx = $signed({2'b00, w_qx});
        w_offy = $signed({2'b00, w_qy});
        if (w_tagx.neg) begin
            w_offx = -w_offx;
        end
        if (w_tagy.neg) begin
            w_offy = -w_offy;
        end
        w_px = (W'(w_stx) <<< FRAC_BITS) + w_offx;
        w_py = (W'(w_sty) <<< FRAC_BITS) + w_offy;
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_tagx.vld;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        o_hit      <= w_tagx.hit;
        o_parallel <= w_tagx.par;
        o_point_x  <= w_tagx.hit ? OW'(w_px) : OW'(0);
        o_point_y  <= w_tagy.hit ? OW'(w_py) : OW'(0);
    end

endmodule

### bench/segment_intersection_unit_tb.sv
// self-checking testbench for the 2d segment intersection unit
// depends on si_pkg and segment_intersection_unit; drives segment pairs, checks crossings
`timescale 1ns / 1ps

module segment_intersection_unit_tb;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int LATENCY    = COORD_BITS + FRAC_BITS + 7;
    localparam int NUM_DIR    = 17;
    localparam int NUM_RANDOM = 1700;

    // one input word: both segments
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax0;
        logic signed [COORD_BITS-1:0] ay0;
        logic signed [COORD_BITS-1:0] ax1;
        logic signed [COORD_BITS-1:0] ay1;
        logic signed [COORD_BITS-1:0] bx0;
        logic signed [COORD_BITS-1:0] by0;
        logic signed [COORD_BITS-1:0] bx1;
        logic signed [COORD_BITS-1:0] by1;
    } t_seg_pair;

    // one result word
    typedef struct packed {
        logic                        hit;
        logic                        par;
        logic [si_pkg::OUT_BITS-1:0] px;
        logic [si_pkg::OUT_BITS-1:0] py;
    } t_crossing;

    // directed row: stimulus, plus a hand-written result where typed is set
    typedef struct packed {
        t_seg_pair pair;
        logic      typed;
        t_crossing want;
    } t_dir_row;

    localparam t_dir_row DIR_TABLE [NUM_DIR] = '{
        // all endpoints at the origin
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b1, 1'b1, 24'h000000, 24'h000000}},
        // point-sized first segment
        '{'{7, 7, 7, 7, 0, 0, 9, 3}, 1'b1, '{1'b1, 1'b1, 24'h000700, 24'h000700}},
        // plain x crossing at (5,5)
        '{'{0, 0, 10, 10, 0, 10, 10, 0}, 1'b1, '{1'b1, 1'b0, 24'h000500, 24'h000500}},
        // clear miss
        '{'{0, 0, 1, 0, 5, 5, 5, 6}, 1'b1, '{1'b0, 1'b0, 24'h000000, 24'h000000}},
        // touching at the end of the first segment
        '{'{0, 0, 4, 0, 4, 0, 4, 4}, 1'b1, '{1'b1, 1'b0, 24'h000400, 24'h000000}},
        // collinear identical segments at the coordinate extremes
        '{'{-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768}, 1'b1,
          '{1'b1, 1'b1, 24'h800000, 24'h7fff00}},
        // parallel with an offset
        '{'{0, 0, 10, 0, 0, 5, 10, 5}, 1'b1, '{1'b1, 1'b1, 24'h000000, 24'h000000}},
        // just past the end of the first segment
        '{'{0, 0, 4, 0, 5, -1, 5, 1}, 1'b1, '{1'b0, 1'b0, 24'h000000, 24'h000000}},
        // full-range diagonals
        '{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}, 1'b0, '0},
        '{'{32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767}, 1'b0, '0},
        '{'{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767}, 1'b0, '0},
        // truncation toward zero, first with negative directions
        '{'{0, 0, -7, -1, -3, 1, -3, -5}, 1'b0, '0},
        '{'{0, 0, 3, 0, 1, -1, 2, 2}, 1'b0, '0},
        // touching at the shared start
        '{'{0, 0, 5, 5, 0, 0, 5, -3}, 1'b0, '0},
        // negative denominator, touching at zero
        '{'{4, 0, 0, 0, 4, 0, 4, 4}, 1'b0, '0},
        // full-range axes crossing at the origin
        '{'{-32768, 0, 32767, 0, 0, -32768, 0, 32767}, 1'b0, '0},
        // short segments far apart
        '{'{-32768, -32768, -32767, -32768, 32767, 32767, 32767, 32766}, 1'b0, '0}
    };

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic signed [COORD_BITS-1:0]        i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y;
    logic signed [COORD_BITS-1:0]        i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y;
    logic                                o_valid;
    logic                                o_hit;
    logic                                o_parallel;
    logic signed [si_pkg::OUT_BITS-1:0]  o_point_x;
    logic signed [si_pkg::OUT_BITS-1:0]  o_point_y;

    t_crossing expected_crossings [$];
    int        fail_count = 0;

    segment_intersection_unit #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_parallel  (o_parallel),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // start + t*dir in fixed point, quotient truncated toward zero
    function automatic logic [si_pkg::OUT_BITS-1:0] place_coord(longint org, longint dir,
                                                                longint tn, longint den);
        longint unsigned scaled, tmag, dmag, quot;
        longint          offs, pos;
        logic            neg;
        scaled = longint'(dir < 0 ? -dir : dir) << FRAC_BITS;
        tmag   = tn < 0 ? -tn : tn;
        dmag   = den < 0 ? -den : den;
        quot   = (scaled * tmag) / dmag;
        neg    = ((dir < 0) != (tn < 0)) != (den < 0);
        offs   = neg ? -longint'(quot) : longint'(quot);
        pos    = org * (longint'(1) << FRAC_BITS) + offs;
        return pos[si_pkg::OUT_BITS-1:0];
    endfunction

    // crossing test on exact cross products
    function automatic t_crossing predict_crossing(t_seg_pair p);
        longint    ax0, ay0, dax, day, dbx, dby, den, ox, oy, sn, tn, dm, sm, tm;
        t_crossing r;
        ax0 = longint'($signed(p.ax0));
        ay0 = longint'($signed(p.ay0));
        dax = longint'($signed(p.ax1)) - ax0;
        day = longint'($signed(p.ay1)) - ay0;
        dbx = longint'($signed(p.bx1)) - longint'($signed(p.bx0));
        dby = longint'($signed(p.by1)) - longint'($signed(p.by0));
        den = dax * dby - dbx * day;
        r   = '0;
        // parallel, collinear or point-sized: report the first start
        if (den == 0) begin
            r.hit = 1'b1;
            r.par = 1'b1;
            r.px  = place_coord(ax0, 0, 0, 1);
            r.py  = place_coord(ay0, 0, 0, 1);
            return r;
        end
        ox = ax0 - longint'($signed(p.bx0));
        oy = ay0 - longint'($signed(p.by0));
        sn = dax * oy - day * ox;
        tn = dbx * oy - dby * ox;
        dm = den < 0 ? -den : den;
        sm = den < 0 ? -sn : sn;
        tm = den < 0 ? -tn : tn;
        // inclusive range checks on both parameters
        if (sm < 0 || sm > dm || tm < 0 || tm > dm)
            return r;
        r.hit = 1'b1;
        r.px  = place_coord(ax0, dax, tn, den);
        r.py  = place_coord(ay0, day, tn, den);
        return r;
    endfunction

    function automatic int rand_coord(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return rand_coord(32768);
        endcase
    endfunction

    // random word: full range, built crossings, small grid, parallels, touches, extremes
    function automatic t_seg_pair make_random_pair();
        t_seg_pair p;
        int        kind, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, mx, my, f, dx, dy, k, j;
        kind = $urandom_range(99);
        ax0 = rand_coord(32767); ay0 = rand_coord(32767);
        ax1 = rand_coord(32767); ay1 = rand_coord(32767);
        bx0 = rand_coord(32767); by0 = rand_coord(32767);
        bx1 = rand_coord(32767); by1 = rand_coord(32767);
        if (kind < 25) begin
            // fully random bits
            ax0 = $urandom; ay0 = $urandom; ax1 = $urandom; ay1 = $urandom;
            bx0 = $urandom; by0 = $urandom; bx1 = $urandom; by1 = $urandom;
        end else if (kind < 55) begin
            // second segment mirrored through a point on the first
            ax0 = rand_coord(10000); ay0 = rand_coord(10000);
            ax1 = rand_coord(10000); ay1 = rand_coord(10000);
            f   = $urandom_range(256);
            mx  = ax0 + (ax1 - ax0) * f / 256;
            my  = ay0 + (ay1 - ay0) * f / 256;
            bx0 = rand_coord(10000); by0 = rand_coord(10000);
            bx1 = 2 * mx - bx0;      by1 = 2 * my - by0;
        end else if (kind < 70) begin
            // small grid: touches, degenerates and parallels come often
            ax0 = rand_coord(8); ay0 = rand_coord(8); ax1 = rand_coord(8); ay1 = rand_coord(8);
            bx0 = rand_coord(8); by0 = rand_coord(8); bx1 = rand_coord(8); by1 = rand_coord(8);
        end else if (kind < 85) begin
            // parallel or collinear pair
            dx  = rand_coord(1000); dy = rand_coord(1000); k = rand_coord(3);
            ax0 = rand_coord(20000); ay0 = rand_coord(20000);
            ax1 = ax0 + dx;          ay1 = ay0 + dy;
            if ($urandom_range(1)) begin
                j   = rand_coord(3);
                bx0 = ax0 + j * dx;  by0 = ay0 + j * dy;
            end else begin
                bx0 = rand_coord(20000); by0 = rand_coord(20000);
            end
            bx1 = bx0 + k * dx;      by1 = by0 + k * dy;
        end else if (kind < 93) begin
            // second segment starts on an endpoint of the first
            if ($urandom_range(1)) begin
                bx0 = ax1; by0 = ay1;
            end else begin
                bx0 = ax0; by0 = ay0;
            end
        end else begin
            ax0 = pick_extreme(); ay0 = pick_extreme();
            ax1 = pick_extreme(); ay1 = pick_extreme();
            bx0 = pick_extreme(); by0 = pick_extreme();
            bx1 = pick_extreme(); by1 = pick_extreme();
        end
        p.ax0 = COORD_BITS'(ax0); p.ay0 = COORD_BITS'(ay0);
        p.ax1 = COORD_BITS'(ax1); p.ay1 = COORD_BITS'(ay1);
        p.bx0 = COORD_BITS'(bx0); p.by0 = COORD_BITS'(by0);
        p.bx1 = COORD_BITS'(bx1); p.by1 = COORD_BITS'(by1);
        return p;
    endfunction

    // present one word, wait for it to be taken, record what must come out
    task automatic send_pair(t_seg_pair p, logic typed, t_crossing want, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_a_start_x <= p.ax0;
        i_a_start_y <= p.ay0;
        i_a_end_x   <= p.ax1;
        i_a_end_y   <= p.ay1;
        i_b_start_x <= p.bx0;
        i_b_start_y <= p.by0;
        i_b_end_x   <= p.bx1;
        i_b_end_y   <= p.by1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        expected_crossings.push_back(typed ? want : predict_crossing(p));
    endtask

    // result checker: every strobed word against the oldest expectation
    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (expected_crossings.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_crossings.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        fail_count++;
                    end
                    if (o_parallel !== want.par) begin
                        $error("parallel: expected %0d, got %0d", want.par, o_parallel);
                        fail_count++;
                    end
                    if (o_point_x !== want.px) begin
                        $error("point_x: expected %h, got %h", want.px, o_point_x);
                        fail_count++;
                    end
                    if (o_point_y !== want.py) begin
                        $error("point_y: expected %h, got %h", want.py, o_point_y);
                        fail_count++;
                    end
                end
            end else if (o_valid !== 1'b0) begin
                $error("valid: expected 0 or 1, got %b", o_valid);
                fail_count++;
            end
        end
    end

    // stimulus: reset, directed table, then three idling phases of random words
    initial begin
        int idle_by_phase [3] = '{22, 69, 0};
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_a_start_x <= '0;
        i_a_start_y <= '0;
        i_a_end_x   <= '0;
        i_a_end_y   <= '0;
        i_b_start_x <= '0;
        i_b_start_y <= '0;
        i_b_end_x   <= '0;
        i_b_end_y   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_DIR; r++)
            send_pair(DIR_TABLE[r].pair, DIR_TABLE[r].typed, DIR_TABLE[r].want, 22);

        for (int ph = 0; ph < 3; ph++) begin
            for (int n = 0; n < NUM_RANDOM / 3; n++)
                send_pair(make_random_pair(), 1'b0, '0, idle_by_phase[ph]);
        end
        start <= 1'b0;

        // drain, then watch for stray words
        while (expected_crossings.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        if (fail_count == 0 && expected_crossings.size() == 0)
            $display("segment_intersection_unit_tb: done, clean");
        else
            $display("segment_intersection_unit_tb: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("segment_intersection_unit_tb: done, errors");
        $finish;
    end

endmodule
